### rtl/ssidm_pkg.sv
// Shared definitions for the sorted set block: operation codes, sequencer states
// and default sizes. No dependencies; imported by the top level.
package ssidm_pkg;

  // Default number of entries the set can hold.
  localparam int unsigned CAPACITY_DEF = 256;

  // Keys are reduced modulo this limit before use.
  localparam longint unsigned KEY_MODULUS = 64'd65536;

  localparam int unsigned KEY_W   = 16;
  localparam int unsigned COUNT_W = 9;
  localparam int unsigned FUNC_W  = 2;

  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_MEMBER = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_START,
    ST_SEARCH,
    ST_EXEC,
    ST_SHIFT_UP,
    ST_PUT,
    ST_SHIFT_DN,
    ST_DONE
  } state_t;

endpackage

### rtl/ssidm_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module ssidm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/sorted_set_insert_delete_member.sv
// Top level of the sorted set: sequencer around one entry RAM.
// Depends on ssidm_pkg and ssidm_ram.
//
//  Channel   Direction  Handshake               Word contents (low bit first)
//  s_axis    in         s_axis_tvalid/tready    tdata: key_value[15:0]; tuser: func[1:0]
//  m_axis    out        m_axis_tvalid/tready    tdata: success, store_full, entry_count[8:0]
//
// A lookup walks the entries from the front and stops on the first one not below
// the key or at the end; an empty set is not read. An insert that stores the key
// then shifts the entries from there up one place, a delete that removes one shifts
// the later entries down, and once the result lands the sequencer returns to idle,
// where the next word is taken. The slowest word, an insert at the front of a set
// holding CAPACITY - 1 entries, is bound by the single read port of the entry RAM,
// which is walked one entry a cycle. When KEY_MODULUS is below 65536 the key is
// first reduced by reciprocal multiplication, quotient first and then remainder.
// Reset (rst, synchronous) empties the set at once; the RAM itself is not cleared,
// since only entries below the count are ever read. A result waits in the output
// register while the next word is taken; the sequencer stalls in its final state
// only if a second result is ready before the first is collected.
module sorted_set_insert_delete_member
  import ssidm_pkg::*;
#(
  parameter int unsigned CAPACITY = CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // key_value[15:0]
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // success, store_full, entry_count[8:0], zero pad
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // Key reduction is only needed when the modulus is narrower than the key field.
  localparam logic NEED_MOD = (KEY_MODULUS < 64'd65536);
  // The quotient of a key is (key * RECIP_C) >> MOD_SH, exact for every 16-bit key.
  localparam longint unsigned MOD_L = NEED_MOD ? KEY_MODULUS : 64'd65535;
  localparam int unsigned MOD_SH = KEY_W + $clog2(MOD_L);
  localparam int unsigned RECIP_W = KEY_W + 2;
  localparam logic [RECIP_W-1:0] RECIP_C =
    RECIP_W'(((64'd1 << MOD_SH) + MOD_L - 64'd1) / MOD_L);
  localparam logic [KEY_W-1:0] MOD_C = KEY_W'(MOD_L);

  state_t state, state_next;

  logic [KEY_W-1:0]  key, key_next;       // operand key
  logic [KEY_W-1:0]  quo, quo_next;       // quotient during reduction
  logic              red_phase, red_phase_next;
  logic [FUNC_W-1:0] op, op_next;
  logic [CW-1:0]     pos, pos_next;       // lower-bound position
  logic [CW-1:0]     idx, idx_next;       // write position while shifting
  logic              found, found_next;
  logic [CW-1:0]     count, count_next;
  logic              res_ok, res_ok_next;
  logic              res_full, res_full_next;
  logic              out_valid, out_valid_next;
  logic [15:0]       out_data, out_data_next;

  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [KEY_W-1:0]  wr_data, rd_data;

  logic [CW-1:0]     pos_inc, idx_dec, idx_dec2, idx_inc, idx_inc2, count_dec;
  logic [KEY_W+RECIP_W-1:0] quo_prod;
  logic [KEY_W-1:0]  mod_prod;

  assign pos_inc   = pos + CW'(1);
  assign idx_dec   = idx - CW'(1);
  assign idx_dec2  = idx - CW'(2);
  assign idx_inc   = idx + CW'(1);
  assign idx_inc2  = idx + CW'(2);
  assign count_dec = count - CW'(1);
  assign quo_prod  = (KEY_W+RECIP_W)'(key) * (KEY_W+RECIP_W)'(RECIP_C);
  assign mod_prod  = quo * MOD_C;

  ssidm_ram #(
    .WIDTH (KEY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
    key       <= key_next;
    quo       <= quo_next;
    red_phase <= red_phase_next;
    op        <= op_next;
    pos       <= pos_next;
    idx       <= idx_next;
    found     <= found_next;
    res_ok    <= res_ok_next;
    res_full  <= res_full_next;
    out_data  <= out_data_next;
  end

  always_comb begin
    state_next     = state;
    key_next       = key;
    quo_next       = quo;
    red_phase_next = red_phase;
    op_next        = op;
    pos_next       = pos;
    idx_next       = idx;
    found_next     = found;
    count_next     = count;
    res_ok_next    = res_ok;
    res_full_next  = res_full;
    out_valid_next = out_valid;
    out_data_next  = out_data;
    rd_en          = 1'b0;
    rd_addr        = '0;
    wr_en          = 1'b0;
    wr_addr        = '0;
    wr_data        = rd_data;

    // The output register empties as soon as the consumer takes the word.
    if (out_valid && m_axis_tready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          key_next = s_axis_tdata;
          op_next  = s_axis_tuser;
          red_phase_next = 1'b0;
          state_next = NEED_MOD ? ST_REDUCE : ST_START;
        end
      end

      // Reduction in two steps: the quotient first, then the key minus the
      // quotient times the modulus.
      ST_REDUCE: begin
        if (!red_phase) begin
          quo_next       = KEY_W'(quo_prod >> MOD_SH);
          red_phase_next = 1'b1;
        end else begin
          key_next   = key - mod_prod;
          state_next = ST_START;
        end
      end

      ST_START: begin
        pos_next   = '0;
        found_next = 1'b0;
        if (count == '0) begin
          state_next = ST_EXEC;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = '0;
          state_next = ST_SEARCH;
        end
      end

      // rd_data holds the entry at pos; the next entry is fetched only if the search goes on.
      ST_SEARCH: begin
        if (rd_data >= key) begin
          found_next = (rd_data == key);
          state_next = ST_EXEC;
        end else begin
          pos_next = pos_inc;
          if (pos_inc == count) begin
            state_next = ST_EXEC;
          end else begin
            rd_en   = 1'b1;
            rd_addr = pos_inc[AW-1:0];
          end
        end
      end

      ST_EXEC: begin
        res_ok_next   = 1'b0;
        res_full_next = 1'b0;
        state_next    = ST_DONE;
        case (op)
          FUNC_INSERT: begin
            if (!found) begin
              if (count == CAP_C) begin
                res_full_next = 1'b1;
              end else if (pos == count) begin
                state_next = ST_PUT;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = count_dec[AW-1:0];
                idx_next   = count;
                state_next = ST_SHIFT_UP;
              end
            end
          end
          FUNC_DELETE: begin
            if (found) begin
              if (pos_inc == count) begin
                count_next  = count_dec;
                res_ok_next = 1'b1;
              end else begin
                rd_en      = 1'b1;
                rd_addr    = pos_inc[AW-1:0];
                idx_next   = pos;
                state_next = ST_SHIFT_DN;
              end
            end
          end
          FUNC_MEMBER: begin
            res_ok_next = found;
          end
          default: begin
            res_ok_next = 1'b0;
          end
        endcase
      end

      // Move entries pos..count-1 up one place, highest first.
      ST_SHIFT_UP: begin
        wr_en    = 1'b1;
        wr_addr  = idx[AW-1:0];
        wr_data  = rd_data;
        idx_next = idx_dec;
        if (idx_dec == pos) begin
          state_next = ST_PUT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_dec2[AW-1:0];
        end
      end

      ST_PUT: begin
        wr_en       = 1'b1;
        wr_addr     = pos[AW-1:0];
        wr_data     = key;
        count_next  = count + CW'(1);
        res_ok_next = 1'b1;
        state_next  = ST_DONE;
      end

      // Move entries pos+1..count-1 down one place, lowest first.
      ST_SHIFT_DN: begin
        wr_en   = 1'b1;
        wr_addr = idx[AW-1:0];
        wr_data = rd_data;
        if (idx_inc2 == count) begin
          count_next  = count_dec;
          res_ok_next = 1'b1;
          state_next  = ST_DONE;
        end else begin
          rd_en    = 1'b1;
          rd_addr  = idx_inc2[AW-1:0];
          idx_next = idx_inc;
        end
      end

      ST_DONE: begin
        if (!out_valid || m_axis_tready) begin
          out_valid_next = 1'b1;
          out_data_next  = {5'b0, COUNT_W'(count), res_full, res_ok};
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### bench/sorted_set_insert_delete_member_test.sv
`timescale 1ns / 100ps
// Self-checking bench for sorted_set_insert_delete_member: table-driven and random
// insert/delete/member words, checked against an in-bench model of the set.
// Depends on ssidm_pkg and the RTL of the block; reads no files.
module sorted_set_insert_delete_member_test;
  import ssidm_pkg::*;

  localparam int unsigned SET_DEPTH = CAPACITY_DEF;
  // The block treats func code 3 as a no-op; the package gives it no name.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  // Worst case per operation is about one pass over the store; the wait covers two passes.
  localparam int unsigned DRAIN_CYCLES = 2 * SET_DEPTH + 64;
  // The receiver stalls once for a long time after this many replies.
  localparam int unsigned HOLD_AT = 40;
  localparam int unsigned HOLD_CYCLES = 3000;
  localparam int unsigned FILL_WORDS = 380;
  localparam int unsigned DRAIN_WORDS = 370;

  typedef struct packed {
    logic               success;
    logic               store_full;
    logic [COUNT_W-1:0] entry_count;
  } set_reply_t;

  // One row of the directed table. Where typed is set, reply holds the answer
  // written by hand; otherwise the set model supplies it.
  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    bit                typed;
    set_reply_t        reply;
  } probe_row_t;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;   // key_value[15:0]
  logic [1:0]  s_axis_tuser;   // func[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // success, store_full, entry_count[8:0], zero pad

  // Bench copy of the set: held_keys[0 .. held_count-1] ascending.
  logic [KEY_W-1:0] held_keys [SET_DEPTH];
  int unsigned      held_count;

  set_reply_t  pending_replies[$];
  probe_row_t  probe_rows[$];
  int unsigned fault_count;
  int unsigned replies_seen;

  sorted_set_insert_delete_member #(
    .CAPACITY(SET_DEPTH)
  ) uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Applies one operation to the bench copy of the set and returns the reply
  // the block must give for it. Keys are first wrapped into the value range.
  function automatic set_reply_t apply_set_op(logic [FUNC_W-1:0] func,
                                              logic [KEY_W-1:0] raw_key);
    logic [KEY_W-1:0] key;
    int unsigned      pos;
    int unsigned      i;
    bit               found;
    set_reply_t       r;
    key = KEY_W'(64'(raw_key) % KEY_MODULUS);
    pos = 0;
    while (pos < held_count && held_keys[pos] < key) pos++;
    found = (pos < held_count) && (held_keys[pos] == key);
    r = '0;
    case (func)
      FUNC_INSERT: begin
        if (!found) begin
          if (held_count >= SET_DEPTH) begin
            r.store_full = 1'b1;
          end else begin
            for (i = held_count; i > pos; i--) held_keys[i] = held_keys[i-1];
            held_keys[pos] = key;
            held_count++;
            r.success = 1'b1;
          end
        end
      end
      FUNC_DELETE: begin
        if (found) begin
          for (i = pos; i + 1 < held_count; i++) held_keys[i] = held_keys[i+1];
          held_count--;
          r.success = 1'b1;
        end
      end
      FUNC_MEMBER: r.success = found;
      default: ;
    endcase
    r.entry_count = COUNT_W'(held_count);
    return r;
  endfunction

  // Idle length before a word. Most gaps are short, a few are long, and every
  // fifth run of 40 words goes through with no gaps at all.
  function automatic int idle_gap(int unsigned idx);
    int unsigned r;
    if ((idx / 40) % 5 == 3) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(12, 70);
  endfunction

  // Picks a key that is held (hit_pct percent of the time), next to a held one,
  // at either end of the key range, or anywhere.
  function automatic logic [KEY_W-1:0] pick_key(int unsigned hit_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (held_count > 0 && r < hit_pct)
      return held_keys[$urandom_range(0, held_count - 1)];
    if (held_count > 0 && r < hit_pct + 10)
      return held_keys[$urandom_range(0, held_count - 1)] + 16'd1;
    if (r >= 95) begin
      if ($urandom_range(0, 1)) return 16'hFFFF - KEY_W'($urandom_range(0, 3));
      return KEY_W'($urandom_range(0, 3));
    end
    return KEY_W'($urandom_range(0, 65535));
  endfunction

  task automatic add_probe(logic [FUNC_W-1:0] func, logic [KEY_W-1:0] key, bit typed,
                           logic ok, logic full, logic [COUNT_W-1:0] count);
    probe_row_t row;
    row.func  = func;
    row.key   = key;
    row.typed = typed;
    row.reply = '{success: ok, store_full: full, entry_count: count};
    probe_rows.push_back(row);
  endtask

  task automatic report_fault(string msg);
    fault_count++;
    if (fault_count <= 10) $display("MISMATCH at %0t: %s", $realtime, msg);
  endtask

  // Offers one word and holds it until the block takes it. The expected reply
  // is queued at the accepting edge, then the line idles for the given gap. With
  // gap zero tvalid stays high for the next word without a glitch.
  task automatic send_word(logic [FUNC_W-1:0] func, logic [KEY_W-1:0] key, bit typed,
                           set_reply_t typed_reply, int gap);
    set_reply_t predicted;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= func;
    s_axis_tdata  <= key;
    do @(posedge clk); while (!s_axis_tready);
    predicted = apply_set_op(func, key);
    pending_replies.push_back(typed ? typed_reply : predicted);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Sender pause: nothing is offered until every reply is back.
  task automatic settle_replies();
    s_axis_tvalid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // Sender: reset, directed table, then a fill phase and a drain phase.
  initial begin
    int unsigned      counted;
    int unsigned      sent;
    int unsigned      r;
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= FUNC_INSERT;
    held_count   = 0;
    fault_count  = 0;
    counted      = 0;
    sent         = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed table. The first rows check the empty set, both ends of the key
    // range, a duplicate insert, and the unused func code; hand-written replies
    // are used there. Later rows insert and delete in the middle and at both
    // ends of the list and take their replies from the model.
    add_probe(FUNC_MEMBER, 16'h0000, 1, 1'b0, 1'b0, 9'd0);
    add_probe(FUNC_DELETE, 16'h0000, 1, 1'b0, 1'b0, 9'd0);
    add_probe(FUNC_INSERT, 16'hFFFF, 1, 1'b1, 1'b0, 9'd1);
    add_probe(FUNC_INSERT, 16'h0000, 1, 1'b1, 1'b0, 9'd2);
    add_probe(FUNC_INSERT, 16'hFFFF, 1, 1'b0, 1'b0, 9'd2);
    add_probe(FUNC_MEMBER, 16'hFFFF, 1, 1'b1, 1'b0, 9'd2);
    add_probe(FUNC_MEMBER, 16'h0000, 1, 1'b1, 1'b0, 9'd2);
    add_probe(FUNC_UNUSED, 16'hFFFF, 1, 1'b0, 1'b0, 9'd2);
    add_probe(FUNC_MEMBER, 16'h8000, 1, 1'b0, 1'b0, 9'd2);
    add_probe(FUNC_INSERT, 16'h8000, 0, 1'b0, 1'b0, 9'd0);
    add_probe(FUNC_INSERT, 16'h7FFF, 0, 1'b0, 1'b0, 9'd0);
    add_probe(FUNC_INSERT, 16'h8001, 0, 1'b0, 1'b0, 9'd0);
    add_probe(FUNC_DELETE, 16'h8000, 0, 1'b0, 1'b0, 9'd0);
    add_probe(FUNC_MEMBER, 16'h7FFF, 0, 1'b0, 1'b0, 9'd0);
    add_probe(FUNC_DELETE, 16'hFFFF, 0, 1'b0, 1'b0, 9'd0);
    add_probe(FUNC_DELETE, 16'hFFFF, 0, 1'b0, 1'b0, 9'd0);
    add_probe(FUNC_DELETE, 16'h0000, 0, 1'b0, 1'b0, 9'd0);
    add_probe(FUNC_UNUSED, 16'h5555, 0, 1'b0, 1'b0, 9'd0);
    add_probe(FUNC_INSERT, 16'h5555, 0, 1'b0, 1'b0, 9'd0);
    add_probe(FUNC_INSERT, 16'hAAAA, 0, 1'b0, 1'b0, 9'd0);
    add_probe(FUNC_MEMBER, 16'hAAAA, 0, 1'b0, 1'b0, 9'd0);
    foreach (probe_rows[i]) begin
      send_word(probe_rows[i].func, probe_rows[i].key, probe_rows[i].typed,
                probe_rows[i].reply, idle_gap(sent));
      sent++;
    end
    settle_replies();

    // Fill phase: mostly inserts of fresh keys, so the set reaches capacity
    // and later inserts of absent keys are refused with the full flag.
    while (counted < FILL_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        func = FUNC_INSERT;
        key  = ($urandom_range(0, 99) < 85) ? KEY_W'($urandom_range(0, 65535))
                                            : pick_key(50);
      end else if (r < 88) begin
        func = FUNC_MEMBER;
        key  = pick_key(50);
      end else if (r < 96) begin
        func = FUNC_DELETE;
        key  = pick_key(50);
      end else begin
        func = FUNC_UNUSED;
        key  = pick_key(30);
      end
      send_word(func, key, 1'b0, '0, idle_gap(sent));
      sent++;
      if (func != FUNC_UNUSED) counted++;
    end
    settle_replies();

    // Drain phase: mostly deletes of held keys, with lookups and a few inserts.
    counted = 0;
    while (counted < DRAIN_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        func = FUNC_INSERT;
        key  = pick_key(20);
      end else if (r < 35) begin
        func = FUNC_MEMBER;
        key  = pick_key(60);
      end else if (r < 95) begin
        func = FUNC_DELETE;
        key  = pick_key(85);
      end else begin
        func = FUNC_UNUSED;
        key  = pick_key(30);
      end
      send_word(func, key, 1'b0, '0, idle_gap(sent));
      sent++;
      if (func != FUNC_UNUSED) counted++;
    end
    settle_replies();

    // Let any straggling work finish so that a stray extra word is caught.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fault_count == 0 && pending_replies.size() == 0) begin
      $display("sorted_set_insert_delete_member verification clean");
    end else begin
      $display("sorted_set_insert_delete_member verification failed");
    end
    $finish;
  end

  // Receiver: random stalls on m_axis_tready plus one long hold-off, during
  // which the sender keeps offering so that the block backs up and drops
  // s_axis_tready. Each word taken is checked against the oldest expectation.
  initial begin
    set_reply_t got;
    set_reply_t want;
    bit         held_off;
    int         gap;
    held_off      = 1'b0;
    replies_seen  = 0;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (replies_seen == HOLD_AT && !held_off) begin
        held_off = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = idle_gap(replies_seen);
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      replies_seen++;
      got.success     = m_axis_tdata[0];
      got.store_full  = m_axis_tdata[1];
      got.entry_count = m_axis_tdata[10:2];
      if (pending_replies.size() == 0) begin
        report_fault($sformatf("unexpected word success=%b full=%b count=%0d",
                               got.success, got.store_full, got.entry_count));
      end else begin
        want = pending_replies.pop_front();
        if (got.success !== want.success || got.store_full !== want.store_full ||
            got.entry_count !== want.entry_count)
          report_fault($sformatf(
            "reply %0d expected success=%b full=%b count=%0d, got %b %b %0d",
            replies_seen, want.success, want.store_full, want.entry_count,
            got.success, got.store_full, got.entry_count));
      end
    end
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #60_000_000;
    $display("sorted_set_insert_delete_member verification failed");
    $finish;
  end

endmodule
